/* sv/racp_pkg.sv */
package racp_pkg;
  localparam int NodeW  = 8;
  localparam int RackW  = 6;
  localparam int FillW  = 6;
  localparam int RemW   = 9;
  localparam int ChunkW = 6;
  localparam int StrW   = 16;
  localparam int RandW  = 31;

  localparam logic [2:0] REG_NODES  = 3'd0;
  localparam logic [2:0] REG_RACKS  = 3'd1;
  localparam logic [2:0] REG_DATA   = 3'd2;
  localparam logic [2:0] REG_PARITY = 3'd3;
  localparam logic [2:0] REG_STRIPE = 3'd4;

  typedef struct packed {
    logic             start;
    logic [RandW-1:0] dividend;
    logic [RemW-1:0]  divisor;
  } div_req_t;
endpackage

/* sv/racp_mod.sv */
module racp_mod (
  input  logic                     clk,
  input  logic                     rst,
  input  racp_pkg::div_req_t       req,
  output logic                     done,
  output logic [racp_pkg::RemW-1:0] rem
);
  import racp_pkg::*;
  // restoring remainder, one bit per cycle
  logic [RandW-1:0] quo;
  logic [RemW:0]    acc;
  logic [RemW-1:0]  dvs;
  logic [4:0]       cnt;
  logic             busy;
  logic [RemW:0]    shifted;
  logic [RemW+1:0]  diff;

  always_comb begin
    shifted = {acc[RemW-1:0], quo[RandW-1]};
    diff = {1'b0, shifted} - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 5'd0;
        quo <= req.dividend;
        acc <= '0;
        dvs <= req.divisor;
      end else if (busy) begin
        quo <= {quo[RandW-2:0], 1'b0};
        acc <= diff[RemW+1] ? shifted : diff[RemW:0];
        cnt <= cnt + 5'd1;
        if (cnt == 5'(RandW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign rem = acc[RemW-1:0];
endmodule

/* sv/rack_aware_random_chunk_placer_core.sv */
// Rack-aware random chunk placer.
// Input channel: random_value with in_valid/in_stall. Each transfer brings
// one draw; exactly one result leaves on the output channel (out_valid /
// out_stall) per draw: accepted, node_index, stripe/chunk position, flags.
// Per draw: slot = value mod remaining nodes, computed by a bit-serial
// remainder unit; then the node list memory is read at the slot and at
// the last entry, the rack is found by repeated subtraction (node /
// nodes-per-rack, clamped to the last rack), the rack fill memory is read,
// and on a placement the rack fill is written back, and the node list too
// unless the chunk is the last of its stripe. One item is in flight. A draw
// with no nodes left is answered in the cycle after its transfer.
// The result sits in an output register; a stall by the receiver holds it
// and the block takes no new draw until it is transferred.
// Reset (and a configuration write to indices 0 to 4) restores the default
// registers or keeps the written one and starts a clearing pass that writes
// the identity node list and zeroes the rack fills, during which in_stall is
// high. The same pass runs after each completed stripe.
module rack_aware_random_chunk_placer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [30:0] random_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  output logic [7:0]  node_index,
  output logic [15:0] stripe_index,
  output logic [5:0]  chunk_index,
  output logic        last_in_stripe,
  output logic        last_stripe
);
  import racp_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_DIV   = 8'b00000100,
    S_RD1   = 8'b00001000,
    S_RD2   = 8'b00010000,
    S_DEC   = 8'b00100000,
    S_OUT   = 8'b01000000,
    S_RD3   = 8'b10000000
  } state_t;

  state_t state;
  logic [8:0]  node_count;
  logic [6:0]  rack_count;
  logic [5:0]  data_chunks, parity_chunks;
  logic [16:0] stripe_count;

  logic [NodeW-1:0] node_mem [256];
  logic [FillW-1:0] fill_mem [64];
  logic [NodeW-1:0] node_rd;
  logic [FillW-1:0] fill_rd;
  logic [NodeW-1:0] node_addr, node_waddr, node_wdata;
  logic             node_we;
  logic [RackW-1:0] fill_addr, fill_waddr, fill_wdata;
  logic             fill_we;

  logic [RemW-1:0]   remaining;
  logic [ChunkW-1:0] chunk_counter;
  logic [StrW-1:0]   stripe_counter;
  logic [8:0]        clr_cnt;
  logic [NodeW-1:0]  slot, node_sel;
  logic [RackW-1:0]  rack;
  logic [8:0]        per_rack;
  div_req_t          dreq;
  logic              ddone;
  logic [RemW-1:0]   drem;
  logic              restart;

  logic [8:0] eff_nodes;
  logic [6:0] eff_racks;
  logic [6:0] eff_chunks;
  logic [16:0] eff_stripes;
  logic [6:0] sum_chunks;

  always_comb begin
    eff_nodes = (node_count == 9'd0) ? 9'd1 : (node_count > 9'd256 ? 9'd256 : node_count);
    eff_racks = (rack_count == 7'd0) ? 7'd1 : (rack_count > 7'd64 ? 7'd64 : rack_count);
    sum_chunks = {1'b0, data_chunks} + {1'b0, parity_chunks};
    eff_chunks = (sum_chunks == 7'd0) ? 7'd1 : (sum_chunks > 7'd64 ? 7'd64 : sum_chunks);
    eff_stripes = (stripe_count == 17'd0) ? 17'd1
                : (stripe_count > 17'd65536 ? 17'd65536 : stripe_count);
  end

  racp_mod u_mod (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .rem(drem));

  // per_rack = nodes / racks, found by repeated subtraction during the pass
  logic [8:0] pr_acc;
  logic [8:0] pr_q;

  assign restart = cfg_we && (cfg_index <= REG_STRIPE);

  // memories
  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    node_rd <= node_mem[node_addr];
  end
  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    fill_rd <= fill_mem[fill_addr];
  end

  logic       last_chunk, last_str, reject;
  always_comb begin
    last_chunk = ({1'b0, chunk_counter} + 7'd1) >= eff_chunks;
    last_str = last_chunk && (({1'b0, stripe_counter} + 17'd1) >= eff_stripes);
    reject = fill_rd >= parity_chunks;
  end

  // rack divider: node / per_rack via a small sequential loop set up in S_RD2 and run in S_RD3
  logic [8:0] rk_acc;
  logic [6:0] rk_q;

  // Read the slot in S_RD1, then hold the last entry on the read port so
  // it is ready to fill the hole in S_DEC.
  always_comb begin
    node_we = 1'b0; node_waddr = '0; node_wdata = '0;
    fill_we = 1'b0; fill_waddr = '0; fill_wdata = '0;
    node_addr = slot; fill_addr = rack;
    if (state == S_CLEAR) begin
      node_we = 1'b1; node_waddr = clr_cnt[7:0]; node_wdata = clr_cnt[7:0];
      fill_we = 1'b1; fill_waddr = clr_cnt[5:0]; fill_wdata = '0;
    end else if (state == S_RD2 || state == S_RD3 || state == S_DEC) begin
      node_addr = 8'(remaining - 9'd1);
    end else if (state == S_OUT && accepted && !last_in_stripe && out_valid == 1'b0) begin
      node_we = 1'b0;
    end
    if (state == S_DEC && !reject && !last_chunk) begin
      node_we = 1'b1; node_waddr = slot; node_wdata = node_rd;
    end
    if (state == S_DEC && !reject) begin
      fill_we = 1'b1; fill_waddr = rack; fill_wdata = fill_rd + 6'd1;
    end
  end

  logic             rk_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr_cnt <= '0; out_valid <= 1'b0;
      node_count <= 9'd16; rack_count <= 7'd4; data_chunks <= 6'd4;
      parity_chunks <= 6'd2; stripe_count <= 17'd1;
      chunk_counter <= '0; stripe_counter <= '0; remaining <= 9'd16;
      pr_acc <= 9'd16; pr_q <= '0;
      dreq.start <= 1'b0;
    end else if (restart) begin
      case (cfg_index)
        REG_NODES:  node_count <= cfg_data[8:0];
        REG_RACKS:  rack_count <= cfg_data[6:0];
        REG_DATA:   data_chunks <= cfg_data[5:0];
        REG_PARITY: parity_chunks <= cfg_data[5:0];
        default:    stripe_count <= cfg_data;
      endcase
      state <= S_CLEAR; clr_cnt <= '0; out_valid <= 1'b0;
      chunk_counter <= '0; stripe_counter <= '0;
      pr_acc <= 9'd0; pr_q <= '0; remaining <= 9'd0;
      dreq.start <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (clr_cnt == 9'd0) begin
            remaining <= eff_nodes; pr_acc <= eff_nodes; pr_q <= '0;
          end else if (pr_acc >= {2'b00, eff_racks}) begin
            pr_acc <= pr_acc - {2'b00, eff_racks}; pr_q <= pr_q + 9'd1;
          end
          clr_cnt <= clr_cnt + 9'd1;
          if (clr_cnt == 9'd255) begin
            state <= S_IDLE;
            per_rack <= '0;
          end
        end
        S_IDLE: begin
          per_rack <= (pr_q == 9'd0) ? 9'd1 : pr_q;
          if (in_valid && !in_stall) begin
            if (remaining == 9'd0) begin
              accepted <= 1'b0; node_index <= '0; last_in_stripe <= 1'b0;
              last_stripe <= 1'b0; stripe_index <= stripe_counter;
              chunk_index <= chunk_counter; out_valid <= 1'b1; state <= S_OUT;
            end else begin
              dreq.start <= 1'b1; dreq.dividend <= random_value;
              dreq.divisor <= remaining; state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          dreq.start <= 1'b0;
          if (ddone) begin
            slot <= drem[7:0]; state <= S_RD1;
          end
        end
        S_RD1: begin
          state <= S_RD2;
        end
        S_RD2: begin
          node_sel <= node_rd;
          rk_acc <= {1'b0, node_rd}; rk_q <= '0; rk_busy <= 1'b1;
          state <= S_RD3;
        end
        S_RD3: begin
          if (rk_busy) begin
            if (rk_acc >= per_rack) begin
              rk_acc <= rk_acc - per_rack; rk_q <= rk_q + 7'd1;
            end else begin
              rk_busy <= 1'b0;
              rack <= (rk_q > eff_racks - 7'd1) ? 6'(eff_racks - 7'd1) : rk_q[5:0];
            end
          end else begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          stripe_index <= stripe_counter; chunk_index <= chunk_counter;
          out_valid <= 1'b1; state <= S_OUT;
          if (reject) begin
            accepted <= 1'b0; node_index <= '0;
            last_in_stripe <= 1'b0; last_stripe <= 1'b0;
          end else begin
            accepted <= 1'b1; node_index <= node_sel;
            last_in_stripe <= last_chunk; last_stripe <= last_str;
            remaining <= remaining - 9'd1;
            if (last_chunk) begin
              stripe_counter <= last_str ? '0 : stripe_counter + 16'd1;
              chunk_counter <= '0;
            end else begin
              chunk_counter <= chunk_counter + 6'd1;
            end
          end
        end
        S_OUT: if (!out_valid || !out_stall) begin
          if (accepted && last_in_stripe) begin
            state <= S_CLEAR; clr_cnt <= '0;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);

  // Hold a stalled result.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && !restart |=> out_valid && $stable(accepted)
      && $stable(node_index) && $stable(chunk_index));
  assert property (@(posedge clk) disable iff (rst) $onehot(state));
  // No draw is taken while a result waits.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall);
  assert property (@(posedge clk) disable iff (rst) remaining <= 9'd256);
endmodule
